// File: hw/rtl/lpf_pkg.sv
package lpf_pkg;

    // Geometry of the snapshot store and its chunks.
    localparam int CHUNK_BYTES    = 16;
    localparam int CHUNK_COUNT    = 11;
    localparam int SNAPSHOT_BYTES = 164;

    localparam int ADDR_W = (SNAPSHOT_BYTES > 1) ? $clog2(SNAPSHOT_BYTES) : 1;
    localparam int POS_W  = $clog2(CHUNK_BYTES * CHUNK_COUNT + SNAPSHOT_BYTES + 256);
    localparam int CIDX_W = (CHUNK_COUNT > 1) ? $clog2(CHUNK_COUNT) : 1;
    localparam int LEN_W  = $clog2(CHUNK_BYTES + 1);
    localparam int CNT_W  = (LEN_W > 3) ? LEN_W : 3;

    localparam int LAST_BASE = CHUNK_BYTES * (CHUNK_COUNT - 1);
    localparam int LAST_REM  = (LAST_BASE >= SNAPSHOT_BYTES) ? 0 : SNAPSHOT_BYTES - LAST_BASE;
    localparam int LAST_LEN  = (LAST_REM > CHUNK_BYTES) ? CHUNK_BYTES : LAST_REM;

    // Input word kinds.
    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_RX   = 2'd1;
    localparam logic [1:0] KIND_DIAG = 2'd2;

    // Result word kinds.
    localparam logic RES_TX  = 1'b0;
    localparam logic RES_CMD = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_START_BYTE   = 2'd0;
    localparam logic [1:0] REG_ENTER_SVC    = 2'd1;
    localparam logic [1:0] REG_ENTER_MON    = 2'd2;
    localparam logic [1:0] REG_RESET_CODE   = 2'd3;

endpackage

// File: hw/rtl/lpf_if.sv
interface lpf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] current_a;
    logic [15:0] current_b;
    logic [15:0] current_c;
    logic [15:0] current_d;
    logic [15:0] bus_voltage;
    logic [7:0]  rx_byte;
    logic        pwm_idle;
    logic [7:0]  diag_index;
    logic [7:0]  diag_byte;

    modport source (
        output valid, kind, current_a, current_b, current_c, current_d,
               bus_voltage, rx_byte, pwm_idle, diag_index, diag_byte,
        input  ready
    );
    modport sink (
        input  valid, kind, current_a, current_b, current_c, current_d,
               bus_voltage, rx_byte, pwm_idle, diag_index, diag_byte,
        output ready
    );
endinterface

interface lpf_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] tx_byte;
    logic       packet_end;
    logic [7:0] command_byte;
    logic       service_mode;
    logic       reset_request;
    logic       pwm_state_clear;
    logic       snapshot_taken;

    modport source (
        output valid, result_kind, tx_byte, packet_end, command_byte,
               service_mode, reset_request, pwm_state_clear, snapshot_taken,
        input  ready
    );
    modport sink (
        input  valid, result_kind, tx_byte, packet_end, command_byte,
               service_mode, reset_request, pwm_state_clear, snapshot_taken,
        output ready
    );
endinterface

// File: hw/rtl/lpf_ram.sv
module lpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 164
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/link_packet_framer_and_command_decoder_unit.sv
// Channel   Dir  Handshake     Word
// i_in      in   valid/ready   send, received byte or staging write
// o_out     out  valid/ready   one packet byte or one doubled command
// apb       in   psel/penable  four 8-bit registers at byte address 4*i
//
// A send word is taken only while idle, and no new word is taken until its packet
// is out: 24 bytes in monitor mode, 20 in service mode (fewer in a short last
// chunk), paced by the single output register and shared 8-bit checksum adder.
// After the packet of the last chunk, a clearing pass zeroes all 164 bytes of the
// new staging bank. A doubled received byte goes on through the command state.
// Reset clears the mode and chunk index, then a clearing pass zeroes both banks
// before the first word is taken. A stalled output holds the emitting states.
module link_packet_framer_and_command_decoder_unit
    import lpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpf_in_if.sink      i_in,
    lpf_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_START = 8'b00000010,
        ST_MEAS  = 8'b00000100,
        ST_INDEX = 8'b00001000,
        ST_CHUNK = 8'b00010000,
        ST_SUM   = 8'b00100000,
        ST_CMD   = 8'b01000000,
        ST_CLEAR = 8'b10000000
    } t_state;

    // Configuration registers.
    logic [7:0] r_start_byte, r_code_svc, r_code_mon, r_code_rst;

    // Sequencer and link state.
    t_state              r_state, n_state;
    logic                r_mode, n_mode;
    logic [CIDX_W-1:0]   r_chunk, n_chunk;
    logic [7:0]          r_prev, n_prev;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [7:0]          r_sum, n_sum;
    logic                r_mon, n_mon;
    logic [31:0]         r_meas, n_meas;
    logic [POS_W-1:0]    r_base, n_base;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic                r_bank, n_bank;
    logic [7:0]          r_cmd, n_cmd;
    logic                r_cmd_svc, n_cmd_svc;
    logic                r_cmd_rst, n_cmd_rst;

    // Clearing pass over the staging bank, or over both banks after reset.
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic                r_clr_all, n_clr_all;
    logic                clr_we;
    logic                r_rd_vld;

    // Output register.
    logic       r_ovld;
    logic       r_res_kind, r_pend, r_svc, r_rst, r_pclr, r_snap;
    logic [7:0] r_tx, r_cbyte;

    logic              in_acc, slot_free, ld, is_last;
    logic              ld_kind, ld_end, ld_svc, ld_rst, ld_pclr, ld_snap;
    logic [7:0]        ld_tx, ld_cbyte, add_in;
    logic [CNT_W-1:0]  chunk_len;
    logic [17:0]       cur_sum;
    logic [7:0]        q0, q1, rd_byte, wdata;
    logic [ADDR_W-1:0] raddr, waddr;
    logic [POS_W-1:0]  diag_pos;
    logic              diag_we, we0, we1;
    logic              cfg_we;

    // ---------------------------------------------------------------- config
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= '0;
            r_code_svc   <= '0;
            r_code_mon   <= '0;
            r_code_rst   <= '0;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                REG_START_BYTE: r_start_byte <= pwdata[7:0];
                REG_ENTER_SVC:  r_code_svc   <= pwdata[7:0];
                REG_ENTER_MON:  r_code_mon   <= pwdata[7:0];
                REG_RESET_CODE: r_code_rst   <= pwdata[7:0];
                default:        r_code_rst   <= r_code_rst;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_START_BYTE: prdata = {24'd0, r_start_byte};
            REG_ENTER_SVC:  prdata = {24'd0, r_code_svc};
            REG_ENTER_MON:  prdata = {24'd0, r_code_mon};
            REG_RESET_CODE: prdata = {24'd0, r_code_rst};
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- stores
    // Two banks trade roles at the end of the last chunk: the staging bank
    // becomes the snapshot, and the old snapshot is cleared as new staging.
    // Bank 1 is the snapshot while r_bank is high, bank 0 otherwise.
    assign diag_pos = POS_W'(i_in.diag_index);
    assign diag_we  = in_acc && (i_in.kind == KIND_DIAG)
                      && (diag_pos < POS_W'(SNAPSHOT_BYTES));
    assign clr_we   = (r_state == ST_CLEAR);
    assign waddr    = clr_we ? r_clr_addr : diag_pos[ADDR_W-1:0];
    assign wdata    = clr_we ? 8'd0 : i_in.diag_byte;
    assign we0      = (diag_we && r_bank) || (clr_we && (r_clr_all || r_bank));
    assign we1      = (diag_we && !r_bank) || (clr_we && (r_clr_all || !r_bank));
    assign raddr    = n_pos[ADDR_W-1:0];

    lpf_ram #(.WIDTH(8), .DEPTH(SNAPSHOT_BYTES)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (q0)
    );

    lpf_ram #(.WIDTH(8), .DEPTH(SNAPSHOT_BYTES)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (q1)
    );

    // Positions past the end of the store read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (n_pos < POS_W'(SNAPSHOT_BYTES));
        end
    end

    assign rd_byte = r_rd_vld ? (r_bank ? q1 : q0) : 8'd0;

    // ---------------------------------------------------------------- sequencer
    assign i_in.ready = (r_state == ST_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign slot_free  = !r_ovld || o_out.ready;
    assign is_last    = (r_chunk == CIDX_W'(CHUNK_COUNT - 1));
    assign chunk_len  = is_last ? CNT_W'(LAST_LEN) : CNT_W'(CHUNK_BYTES);
    assign cur_sum    = 18'(i_in.current_a) + 18'(i_in.current_b)
                      + 18'(i_in.current_c) + 18'(i_in.current_d);

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_chunk    = r_chunk;
        n_prev     = r_prev;
        n_cnt      = r_cnt;
        n_sum      = r_sum;
        n_mon      = r_mon;
        n_meas     = r_meas;
        n_base     = r_base;
        n_pos      = r_pos;
        n_bank     = r_bank;
        n_cmd      = r_cmd;
        n_cmd_svc  = r_cmd_svc;
        n_cmd_rst  = r_cmd_rst;
        n_clr_addr = r_clr_addr;
        n_clr_all  = r_clr_all;
        ld         = 1'b0;
        ld_kind    = RES_TX;
        ld_tx      = 8'd0;
        ld_end     = 1'b0;
        ld_cbyte   = 8'd0;
        ld_svc     = 1'b0;
        ld_rst     = 1'b0;
        ld_pclr    = r_mon;
        ld_snap    = 1'b0;
        add_in     = 8'd0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.kind == KIND_SEND) begin
                        n_state = ST_START;
                        n_cnt   = '0;
                        n_sum   = 8'd0;
                        n_mon   = !r_mode;
                        n_meas  = {i_in.bus_voltage, cur_sum[17:2]};
                    end else if (i_in.kind == KIND_RX) begin
                        n_prev = i_in.rx_byte;
                        if (i_in.rx_byte == r_prev) begin
                            n_state   = ST_CMD;
                            n_cmd     = i_in.rx_byte;
                            n_cmd_svc = r_mode;
                            n_cmd_rst = 1'b0;
                            // A mode code wins over an equal reset code.
                            if (!r_mode) begin
                                if (i_in.rx_byte == r_code_svc) begin
                                    n_mode = 1'b1;
                                end else if (i_in.rx_byte == r_code_rst) begin
                                    n_cmd_rst = 1'b1;
                                end
                            end else begin
                                if (i_in.rx_byte == r_code_mon) begin
                                    if (i_in.pwm_idle) begin
                                        n_mode = 1'b0;
                                    end
                                end else if (i_in.rx_byte == r_code_rst) begin
                                    n_cmd_rst = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            ST_START: begin
                if (slot_free) begin
                    ld    = 1'b1;
                    ld_tx = r_start_byte;
                    if (r_cnt == CNT_W'(1)) begin
                        n_cnt   = '0;
                        n_state = r_mon ? ST_MEAS : ST_INDEX;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            ST_MEAS: begin
                if (slot_free) begin
                    ld     = 1'b1;
                    ld_tx  = r_meas[7:0];
                    add_in = r_meas[7:0];
                    n_sum  = r_sum + add_in;
                    n_meas = {8'd0, r_meas[31:8]};
                    if (r_cnt == CNT_W'(3)) begin
                        n_cnt   = '0;
                        n_state = ST_INDEX;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            ST_INDEX: begin
                if (slot_free) begin
                    ld      = 1'b1;
                    ld_tx   = 8'(r_chunk);
                    n_cnt   = '0;
                    n_state = (chunk_len == '0) ? ST_SUM : ST_CHUNK;
                end
            end
            ST_CHUNK: begin
                if (slot_free) begin
                    ld     = 1'b1;
                    ld_tx  = rd_byte;
                    add_in = rd_byte;
                    n_sum  = r_sum + add_in;
                    n_pos  = r_pos + POS_W'(1);
                    if (r_cnt == chunk_len - CNT_W'(1)) begin
                        n_state = ST_SUM;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            ST_SUM: begin
                if (slot_free) begin
                    ld      = 1'b1;
                    ld_tx   = r_sum;
                    ld_end  = 1'b1;
                    ld_snap = is_last;
                    n_state = ST_IDLE;
                    if (is_last) begin
                        n_chunk = '0;
                        n_base  = '0;
                        n_bank  = !r_bank;
                        n_state = ST_CLEAR;
                    end else begin
                        n_chunk = r_chunk + CIDX_W'(1);
                        n_base  = r_base + POS_W'(CHUNK_BYTES);
                    end
                    n_pos = n_base;
                end
            end
            ST_CMD: begin
                if (slot_free) begin
                    ld       = 1'b1;
                    ld_kind  = RES_CMD;
                    ld_cbyte = r_cmd;
                    ld_svc   = r_cmd_svc;
                    ld_rst   = r_cmd_rst;
                    ld_pclr  = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(SNAPSHOT_BYTES - 1)) begin
                    n_clr_addr = '0;
                    n_clr_all  = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_mode     <= 1'b0;
            r_chunk    <= '0;
            r_prev     <= 8'd0;
            r_cnt      <= '0;
            r_base     <= '0;
            r_pos      <= '0;
            r_bank     <= 1'b0;
            r_clr_addr <= '0;
            r_clr_all  <= 1'b1;
            r_ovld     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_chunk    <= n_chunk;
            r_prev     <= n_prev;
            r_cnt      <= n_cnt;
            r_base     <= n_base;
            r_pos      <= n_pos;
            r_bank     <= n_bank;
            r_clr_addr <= n_clr_addr;
            r_clr_all  <= n_clr_all;
            if (ld) begin
                r_ovld <= 1'b1;
            end else if (o_out.ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum     <= n_sum;
        r_mon     <= n_mon;
        r_meas    <= n_meas;
        r_cmd     <= n_cmd;
        r_cmd_svc <= n_cmd_svc;
        r_cmd_rst <= n_cmd_rst;
        if (ld) begin
            r_res_kind <= ld_kind;
            r_tx       <= ld_tx;
            r_pend     <= ld_end;
            r_cbyte    <= ld_cbyte;
            r_svc      <= ld_svc;
            r_rst      <= ld_rst;
            r_pclr     <= ld_pclr;
            r_snap     <= ld_snap;
        end
    end

    assign o_out.valid           = r_ovld;
    assign o_out.result_kind     = r_res_kind;
    assign o_out.tx_byte         = r_tx;
    assign o_out.packet_end      = r_pend;
    assign o_out.command_byte    = r_cbyte;
    assign o_out.service_mode    = r_svc;
    assign o_out.reset_request   = r_rst;
    assign o_out.pwm_state_clear = r_pclr;
    assign o_out.snapshot_taken  = r_snap;

    // ---------------------------------------------------------------- checks
    a_snap_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && r_snap |-> r_pend && (r_res_kind == RES_TX))
        else $error("snapshot flag away from the checksum word");

    a_cmd_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && (r_res_kind == RES_CMD) |-> (r_tx == 8'd0) && !r_pend && !r_pclr)
        else $error("command word carries packet fields");

    a_chunk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHUNK) |-> (r_cnt < chunk_len))
        else $error("chunk byte count past chunk length");

    a_mode_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_mode) && $past(i_rst_n) |->
            $past(in_acc && (i_in.kind == KIND_RX) && i_in.pwm_idle))
        else $error("service mode left without an idle return command");

endmodule

// File: sim/lpf_checker.sv
module lpf_checker
    import lpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpf_in_if           in_ch,
    lpf_out_if          out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked,
    output int          o_snapshots
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic {LINK_MONITOR, LINK_SERVICE} t_link_mode;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] tx_byte;
        logic       packet_end;
        logic [7:0] command_byte;
        logic       service_mode;
        logic       reset_request;
        logic       pwm_state_clear;
        logic       snapshot_taken;
    } t_link_result;

    logic [7:0] start_code;
    logic [7:0] svc_code;
    logic [7:0] mon_code;
    logic [7:0] rst_code;

    t_link_mode mode;
    int         chunk_idx;
    logic [7:0] prev_rx;
    logic [7:0] snap_mem  [SNAPSHOT_BYTES];
    logic [7:0] stage_mem [SNAPSHOT_BYTES];

    t_link_result results_q [$];

    int err_cnt     = 0;
    int checked_cnt = 0;
    int snap_cnt    = 0;

    assign o_errors    = err_cnt;
    assign o_checked   = checked_cnt;
    assign o_snapshots = snap_cnt;

    task automatic push_result(input logic rk, input logic [7:0] tx, input logic last,
                               input logic [7:0] cmd, input logic svc, input logic rst,
                               input logic clr, input logic snap);
        t_link_result r;
        r.result_kind     = rk;
        r.tx_byte         = tx;
        r.packet_end      = last;
        r.command_byte    = cmd;
        r.service_mode    = svc;
        r.reset_request   = rst;
        r.pwm_state_clear = clr;
        r.snapshot_taken  = snap;
        results_q.push_back(r);
    endtask

    task automatic frame_packet(input logic [15:0] ca, input logic [15:0] cb,
                                input logic [15:0] cc, input logic [15:0] cd,
                                input logic [15:0] vb);
        logic        mon;
        logic [17:0] total;
        logic [7:0]  meas [4];
        logic [7:0]  sum;
        logic [7:0]  b;
        logic        taken;
        int          idx;
        int          len;
        int          pos;
        mon   = (mode == LINK_MONITOR);
        idx   = chunk_idx;
        len   = (idx < CHUNK_COUNT - 1) ? CHUNK_BYTES : LAST_LEN;
        sum   = 8'd0;
        taken = 1'b0;
        repeat (2) push_result(RES_TX, start_code, 1'b0, 8'd0, 1'b0, 1'b0, mon, 1'b0);
        if (mon) begin
            // Mean of the four currents, then the bus voltage, low byte first.
            total   = 18'(ca) + 18'(cb) + 18'(cc) + 18'(cd);
            meas[0] = total[9:2];
            meas[1] = total[17:10];
            meas[2] = vb[7:0];
            meas[3] = vb[15:8];
            foreach (meas[k]) begin
                sum += meas[k];
                push_result(RES_TX, meas[k], 1'b0, 8'd0, 1'b0, 1'b0, 1'b1, 1'b0);
            end
        end
        push_result(RES_TX, 8'(idx), 1'b0, 8'd0, 1'b0, 1'b0, mon, 1'b0);
        for (int k = 0; k < len; k++) begin
            pos = CHUNK_BYTES * idx + k;
            b   = (pos < SNAPSHOT_BYTES) ? snap_mem[pos] : 8'd0;
            sum += b;
            push_result(RES_TX, b, 1'b0, 8'd0, 1'b0, 1'b0, mon, 1'b0);
        end
        if (idx >= CHUNK_COUNT - 1) begin
            chunk_idx = 0;
            snap_mem  = stage_mem;
            foreach (stage_mem[k]) stage_mem[k] = 8'd0;
            taken = 1'b1;
            snap_cnt++;
        end else begin
            chunk_idx = idx + 1;
        end
        push_result(RES_TX, sum, 1'b1, 8'd0, 1'b0, 1'b0, mon, taken);
    endtask

    task automatic decode_rx(input logic [7:0] b, input logic pwm_idle);
        logic was_svc;
        logic rst;
        was_svc = (mode == LINK_SERVICE);
        rst     = 1'b0;
        if (b == prev_rx) begin
            // A mode switch wins over a reset request when the codes coincide.
            if (!was_svc) begin
                if (b == svc_code) begin
                    mode = LINK_SERVICE;
                end else if (b == rst_code) begin
                    rst = 1'b1;
                end
            end else begin
                if (b == mon_code) begin
                    if (pwm_idle) mode = LINK_MONITOR;
                end else if (b == rst_code) begin
                    rst = 1'b1;
                end
            end
            push_result(RES_CMD, 8'd0, 1'b0, b, was_svc, rst, 1'b0, 1'b0);
        end
        prev_rx = b;
    endtask

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
            err_cnt++;
        end
    endtask

    task automatic check_word();
        t_link_result want;
        if (results_q.size() == 0) begin
            $error("unexpected result word: result_kind %0d tx_byte 0x%0h command_byte 0x%0h",
                   out_ch.result_kind, out_ch.tx_byte, out_ch.command_byte);
            err_cnt++;
        end else begin
            want = results_q.pop_front();
            check_field("result_kind", want.result_kind, out_ch.result_kind);
            check_field("tx_byte", want.tx_byte, out_ch.tx_byte);
            check_field("packet_end", want.packet_end, out_ch.packet_end);
            check_field("command_byte", want.command_byte, out_ch.command_byte);
            check_field("service_mode", want.service_mode, out_ch.service_mode);
            check_field("reset_request", want.reset_request, out_ch.reset_request);
            check_field("pwm_state_clear", want.pwm_state_clear, out_ch.pwm_state_clear);
            check_field("snapshot_taken", want.snapshot_taken, out_ch.snapshot_taken);
            checked_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start_code = 8'd0;
            svc_code   = 8'd0;
            mon_code   = 8'd0;
            rst_code   = 8'd0;
            mode       = LINK_MONITOR;
            chunk_idx  = 0;
            prev_rx    = 8'd0;
            foreach (snap_mem[k]) snap_mem[k] = 8'd0;
            foreach (stage_mem[k]) stage_mem[k] = 8'd0;
            results_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_START_BYTE: start_code = pwdata[7:0];
                    REG_ENTER_SVC:  svc_code   = pwdata[7:0];
                    REG_ENTER_MON:  mon_code   = pwdata[7:0];
                    REG_RESET_CODE: rst_code   = pwdata[7:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                case (in_ch.kind)
                    KIND_SEND: frame_packet(in_ch.current_a, in_ch.current_b,
                                            in_ch.current_c, in_ch.current_d,
                                            in_ch.bus_voltage);
                    KIND_RX:   decode_rx(in_ch.rx_byte, in_ch.pwm_idle);
                    KIND_DIAG: begin
                        if (in_ch.diag_index < SNAPSHOT_BYTES)
                            stage_mem[in_ch.diag_index] = in_ch.diag_byte;
                    end
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) check_word();
        end
        o_pending <= results_q.size();
    end

endmodule

// File: sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lpf_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int WORDS_PER_PHASE = 125;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] current_a;
        logic [15:0] current_b;
        logic [15:0] current_c;
        logic [15:0] current_d;
        logic [15:0] bus_voltage;
        logic [7:0]  rx_byte;
        logic        pwm_idle;
        logic [7:0]  diag_index;
        logic [7:0]  diag_byte;
    } t_link_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int errors;
    int pending;
    int checked;
    int snapshots;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_reqs     = 0;
    int cycle_cnt     = 0;
    int words_sent    = 0;
    int packets_sent  = 0;
    int rx_sent       = 0;

    logic [7:0] cur_code [4];

    lpf_in_if  in_ch ();
    lpf_out_if out_ch ();

    link_packet_framer_and_command_decoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lpf_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_snapshots (snapshots)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold-off per request.
    initial begin : receiver
        int holds_done;
        holds_done = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != holds_done) begin
                holds_done++;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_link_word noise_word(input logic [1:0] kind);
        t_link_word w;
        w             = t_link_word'({$urandom, $urandom, $urandom, $urandom});
        w.kind        = kind;
        return w;
    endfunction

    task automatic offer(input t_link_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.kind        <= w.kind;
        in_ch.current_a   <= w.current_a;
        in_ch.current_b   <= w.current_b;
        in_ch.current_c   <= w.current_c;
        in_ch.current_d   <= w.current_d;
        in_ch.bus_voltage <= w.bus_voltage;
        in_ch.rx_byte     <= w.rx_byte;
        in_ch.pwm_idle    <= w.pwm_idle;
        in_ch.diag_index  <= w.diag_index;
        in_ch.diag_byte   <= w.diag_byte;
        do @(posedge i_clk); while (!in_ch.ready);
        words_sent++;
        if (w.kind == KIND_SEND) packets_sent++;
        if (w.kind == KIND_RX) rx_sent++;
    endtask

    task automatic send_pkt(input logic [15:0] ca, input logic [15:0] cb,
                            input logic [15:0] cc, input logic [15:0] cd,
                            input logic [15:0] vb);
        t_link_word w;
        w             = noise_word(KIND_SEND);
        w.current_a   = ca;
        w.current_b   = cb;
        w.current_c   = cc;
        w.current_d   = cd;
        w.bus_voltage = vb;
        offer(w);
    endtask

    task automatic rx_word(input logic [7:0] b, input logic idle);
        t_link_word w;
        w          = noise_word(KIND_RX);
        w.rx_byte  = b;
        w.pwm_idle = idle;
        offer(w);
    endtask

    task automatic diag_word(input logic [7:0] pos, input logic [7:0] b);
        t_link_word w;
        w            = noise_word(KIND_DIAG);
        w.diag_index = pos;
        w.diag_byte  = b;
        offer(w);
    endtask

    task automatic random_send();
        send_pkt(pick_sample(), pick_sample(), pick_sample(), pick_sample(), pick_sample());
    endtask

    task automatic random_item(inout int cnt);
        logic [7:0] b;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 40) begin
            random_send();
            cnt++;
        end else if (pick < 68) begin
            diag_word(8'($urandom_range(SNAPSHOT_BYTES - 1)), 8'($urandom));
            cnt++;
        end else if (pick < 95) begin
            // Mostly doubled bytes, often one of the live codes.
            case ($urandom_range(4))
                0:       b = cur_code[REG_ENTER_SVC];
                1:       b = cur_code[REG_ENTER_MON];
                2:       b = cur_code[REG_RESET_CODE];
                default: b = 8'($urandom);
            endcase
            rx_word(b, 1'($urandom));
            cnt++;
            if ($urandom_range(9) < 6) begin
                rx_word(b, 1'($urandom));
                cnt++;
            end
        end else if ($urandom_range(1) == 0) begin
            offer(noise_word(KIND_UNUSED));
        end else begin
            diag_word(8'($urandom_range(255, SNAPSHOT_BYTES)), 8'($urandom));
        end
    endtask

    // Stop offering words and wait until every predicted word has come out.
    task automatic quiesce();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] ridx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ridx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        cur_code[ridx] = val;
    endtask

    task automatic load_codes(input logic [7:0] start, input logic [7:0] svc,
                              input logic [7:0] mon, input logic [7:0] rst);
        quiesce();
        cfg_write(REG_START_BYTE, start);
        cfg_write(REG_ENTER_SVC, svc);
        cfg_write(REG_ENTER_MON, mon);
        cfg_write(REG_RESET_CODE, rst);
    endtask

    initial begin : stimulus
        int count;
        bit held;
        bit paused;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= 4'd0;
        pwdata            <= 32'd0;
        in_ch.valid       <= 1'b0;
        in_ch.kind        <= KIND_SEND;
        in_ch.current_a   <= 16'd0;
        in_ch.current_b   <= 16'd0;
        in_ch.current_c   <= 16'd0;
        in_ch.current_d   <= 16'd0;
        in_ch.bus_voltage <= 16'd0;
        in_ch.rx_byte     <= 8'd0;
        in_ch.pwm_idle    <= 1'b0;
        in_ch.diag_index  <= 8'd0;
        in_ch.diag_byte   <= 8'd0;
        foreach (cur_code[k]) cur_code[k] = 8'd0;
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 31;
        recv_idle_pct = 64;

        // With every code at zero, a first zero byte already counts as doubled and
        // the mode switch beats the reset request.
        rx_word(8'h00, 1'b0);
        send_pkt(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        rx_word(8'h00, 1'b0);
        rx_word(8'h00, 1'b1);
        send_pkt(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pkt(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        load_codes(8'hA5, 8'h5A, 8'h3C, 8'hC3);
        diag_word(8'd0, 8'hFF);
        diag_word(8'(SNAPSHOT_BYTES - 1), 8'h81);
        diag_word(8'(SNAPSHOT_BYTES), 8'h77);
        diag_word(8'hFF, 8'h11);
        offer(noise_word(KIND_UNUSED));
        rx_word(8'h12, 1'b1);
        rx_word(8'h34, 1'b1);
        rx_word(8'hC3, 1'b0);
        rx_word(8'hC3, 1'b0);
        rx_word(8'h5A, 1'b0);
        rx_word(8'h5A, 1'b0);
        send_pkt(16'h1234, 16'h8000, 16'h0001, 16'hFFFE, 16'h00FF);
        rx_word(8'hC3, 1'b1);
        rx_word(8'hC3, 1'b1);
        rx_word(8'h3C, 1'b1);
        rx_word(8'h3C, 1'b1);
        send_pkt(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFF00);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: ;
                1: begin
                    send_idle_pct = 64;
                    recv_idle_pct = 31;
                    load_codes(8'h00, 8'hFF, 8'h00, 8'hFF);
                end
                2: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    load_codes(8'hFF, 8'h00, 8'hFF, 8'hFF);
                end
                default: begin
                    load_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                end
            endcase
            count  = 0;
            held   = 1'b0;
            paused = 1'b0;
            while (count < WORDS_PER_PHASE) begin
                if (ph == 0 && !paused && count >= 60) begin
                    quiesce();
                    paused = 1'b1;
                end
                if (ph == 2 && !held && count >= 40) begin
                    // Keep sending while the result side is held off so the block
                    // fills up and stops taking words.
                    hold_reqs++;
                    repeat (12) random_send();
                    count += 12;
                    held = 1'b1;
                end
                random_item(count);
            end
        end

        quiesce();
        repeat (16) @(posedge i_clk);
        $display("Run covered %0d input words: %0d packets, %0d received bytes.",
                 words_sent, packets_sent, rx_sent);
        $display("Checked %0d result words across %0d snapshot refreshes and five code sets.",
                 checked, snapshots);
        if (errors == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/lpf_pkg.sv
hw/rtl/lpf_if.sv
hw/rtl/lpf_ram.sv
hw/rtl/link_packet_framer_and_command_decoder_unit.sv
sim/lpf_checker.sv
sim/tb_top.sv
